// ----- rtl/lbh_pkg.sv -----
// ----------------------------------------------------------------------------
// lbh_pkg
// Shared constants and types for the minhash band bucket hash core.
// ----------------------------------------------------------------------------
package lbh_pkg;

	localparam int SIG_LEN      = 100;
	localparam int BAND_LEN     = 25;
	localparam int MAX_VERTICES = 1048576;

	localparam int POS_W     = $clog2(SIG_LEN);
	localparam int IN_BAND_W = (BAND_LEN > 1) ? $clog2(BAND_LEN) : 1;
	localparam int VERTEX_W  = 20;
	localparam int BAND_W    = 2;
	localparam int BUCKET_W  = 20;
	localparam int DATA_W    = 32;

	localparam logic [DATA_W-1:0] DEFAULT_BASE = 32'd103867;
	localparam logic [DATA_W-1:0] SKIP_MARK    = 32'h7fff_ffff;

	localparam longint BUCKET_COUNT = 1040657;

	// offset that lifts a signed sum to a non-negative value with equal residue
	localparam logic [32:0] OFFSET_C =
		33'(BUCKET_COUNT - ((64'd1 << 31) % BUCKET_COUNT));
	// reciprocal for quotient estimate, error at most one
	localparam int RECIP_SHIFT = 33;
	localparam int RECIP_W     = 14;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / BUCKET_COUNT);
	localparam logic [BUCKET_W-1:0] BUCKET_MOD = BUCKET_W'(BUCKET_COUNT);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [DATA_W-1:0]   sum;
		logic [VERTEX_W-1:0] vertex;
		logic [BAND_W-1:0]   band;
	} band_req_t;

endpackage

// ----- rtl/lbh_front.sv -----
// ----------------------------------------------------------------------------
// lbh_front
// Accepts signature elements, tracks position, band and vertex, applies the
// running weight power and accumulates band sums; queues non-skipped bands.
// ----------------------------------------------------------------------------
module lbh_front import lbh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [DATA_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sig_value,
	output logic                     push_valid,
	input  logic                     push_ready,
	output band_req_t                push_data
);

	logic [DATA_W-1:0]    base_q;
	logic [DATA_W-1:0]    wp_q;
	logic [DATA_W-1:0]    sum_q;
	logic [POS_W-1:0]     elem_pos_q;
	logic [IN_BAND_W-1:0] in_band_q;
	logic [BAND_W-1:0]    band_q;
	logic [VERTEX_W-1:0]  vertex_q;
	logic                 skip_q;

	logic                 valid_s1;
	logic [DATA_W-1:0]    prod_s1;
	logic                 band_end_s1;
	logic                 emit_s1;
	logic [VERTEX_W-1:0]  vertex_s1;
	logic [BAND_W-1:0]    band_s1;

	logic                 accept;
	logic                 advance;
	logic                 last_elem;
	logic                 band_end;
	logic                 skip_now;
	logic [DATA_W-1:0]    prod;
	logic [DATA_W-1:0]    sum_next;

	assign last_elem = (elem_pos_q == POS_W'(SIG_LEN - 1));
	assign band_end  = (in_band_q == IN_BAND_W'(BAND_LEN - 1)) || last_elem;
	assign skip_now  = (elem_pos_q == '0) ? ($unsigned(sig_value) == SKIP_MARK) : skip_q;
	assign prod      = $unsigned(sig_value) * wp_q;

	assign sum_next   = sum_q + prod_s1;
	assign push_valid = valid_s1 && band_end_s1 && emit_s1;
	assign advance    = valid_s1 && (!(band_end_s1 && emit_s1) || push_ready);
	assign in_ready   = !valid_s1 || advance;
	assign accept     = in_valid && in_ready;

	assign push_data.sum    = sum_next;
	assign push_data.vertex = vertex_s1;
	assign push_data.band   = band_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= DEFAULT_BASE;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// element, band and vertex tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= DATA_W'(1);
			elem_pos_q <= '0;
			in_band_q  <= '0;
			band_q     <= '0;
			vertex_q   <= '0;
			skip_q     <= 1'b0;
		end else if (accept) begin
			skip_q <= skip_now;
			if (band_end) begin
				wp_q      <= DATA_W'(1);
				in_band_q <= '0;
				band_q    <= band_q + BAND_W'(1);
			end else begin
				wp_q      <= wp_q * base_q;
				in_band_q <= in_band_q + IN_BAND_W'(1);
			end
			if (last_elem) begin
				elem_pos_q <= '0;
				band_q     <= '0;
				if (vertex_q == VERTEX_W'(MAX_VERTICES - 1)) begin
					vertex_q <= '0;
				end else begin
					vertex_q <= vertex_q + VERTEX_W'(1);
				end
			end else begin
				elem_pos_q <= elem_pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				sum_q <= band_end_s1 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1     <= prod;
			band_end_s1 <= band_end;
			emit_s1     <= !skip_now;
			vertex_s1   <= vertex_q;
			band_s1     <= band_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		elem_pos_q <= POS_W'(SIG_LEN - 1))
		else $error("element position out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(prod_s1) && $stable(sum_q))
		else $error("stalled stage lost its contents");
`endif

endmodule

// ----- rtl/lbh_queue.sv -----
// ----------------------------------------------------------------------------
// lbh_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module lbh_queue import lbh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  band_req_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output band_req_t pop_data
);

	band_req_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ----- rtl/lbh_back.sv -----
// ----------------------------------------------------------------------------
// lbh_back
// Reduces each band sum floor-modulo the bucket count through a reciprocal
// multiply pipeline and holds the result in the output register.
// ----------------------------------------------------------------------------
module lbh_back import lbh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  band_req_t           pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BUCKET_W-1:0] bucket_index,
	output logic [VERTEX_W-1:0] vertex_index,
	output logic [BAND_W-1:0]   band_index
);

	localparam int EST_W = 33 + RECIP_W;

	logic                en;

	logic                valid_s1, valid_s2, valid_s3;
	logic [32:0]         u_s1, u_s2, u_s3;
	logic [EST_W-1:0]    est_s2;
	logic [32:0]         qm_s3;
	logic [VERTEX_W-1:0] vertex_s1, vertex_s2, vertex_s3;
	logic [BAND_W-1:0]   band_s1, band_s2, band_s3;

	logic                out_valid_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [VERTEX_W-1:0] vertex_q;
	logic [BAND_W-1:0]   band_q;

	logic [RECIP_W-1:0]  quot;
	logic [32:0]         diff;
	logic [32:0]         rem;

	assign en        = !out_valid_q || out_ready;
	assign pop_ready = en;

	assign quot = est_s2[EST_W-1:RECIP_SHIFT];
	assign diff = u_s3 - qm_s3;
	assign rem  = (diff >= 33'(BUCKET_MOD)) ? diff - 33'(BUCKET_MOD) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// flip sign bit: offset by 2^31, then add residue correction
			u_s1      <= {1'b0, ~pop_data.sum[DATA_W-1], pop_data.sum[DATA_W-2:0]} + OFFSET_C;
			vertex_s1 <= pop_data.vertex;
			band_s1   <= pop_data.band;

			est_s2    <= u_s1 * RECIP;
			u_s2      <= u_s1;
			vertex_s2 <= vertex_s1;
			band_s2   <= band_s1;

			qm_s3     <= 33'(quot) * 33'(BUCKET_MOD);
			u_s3      <= u_s2;
			vertex_s3 <= vertex_s2;
			band_s3   <= band_s2;

			bucket_q  <= rem[BUCKET_W-1:0];
			vertex_q  <= vertex_s3;
			band_q    <= band_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;
	assign vertex_index = vertex_q;
	assign band_index   = band_q;

`ifndef NO_ASSERTIONS
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> bucket_q < BUCKET_MOD)
		else $error("bucket out of range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> diff < 33'(2 * BUCKET_COUNT))
		else $error("quotient estimate off by more than one");
`endif

endmodule

// ----- rtl/lsh_band_bucket_hash_core.sv -----
// ----------------------------------------------------------------------------
// lsh_band_bucket_hash_core
// Minhash band hashing: weighted band sums of signature elements reduced to
// bucket numbers, one request per band of each non-skipped vertex.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   sig_value
// out       output     out_valid / out_ready bucket_index, vertex_index, band_index
// cfg       input      cfg_we                cfg_wdata (hash_base)
//
// one input request per cycle while the queue has room, set by the weight power multiply loop
// a band result passes the front stage register, the queue and back stages s1 to s3 to the output register
// asynchronous reset clears all control state, hash_base returns to 103867
// a four-entry queue lets the front keep taking input while the output stalls
// ----------------------------------------------------------------------------
module lsh_band_bucket_hash_core import lbh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [DATA_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sig_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [BUCKET_W-1:0]      bucket_index,
	output logic [VERTEX_W-1:0]      vertex_index,
	output logic [BAND_W-1:0]        band_index
);

	logic      push_valid;
	logic      push_ready;
	band_req_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	band_req_t pop_data;

	lbh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sig_value  (sig_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lbh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lbh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.vertex_index (vertex_index),
		.band_index   (band_index)
	);

endmodule

// ----- sim/lsh_band_bucket_hash_core_tb.sv -----
// ----------------------------------------------------------------------------
// lsh_band_bucket_hash_core_tb
// Streams minhash signature values into the band hash core and checks every
// band bucket it returns against a cycle-free model of the banding hash. The
// hash base is changed between phases, including once in the middle of a
// band, and both sides of the stream idle at random outside burst phases.
// ----------------------------------------------------------------------------
module lsh_band_bucket_hash_core_tb;
	import lbh_pkg::*;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket;
		logic [VERTEX_W-1:0] vertex;
		logic [BAND_W-1:0]   band;
	} band_bucket_t;

	typedef enum int {
		VK_RANDOM,
		VK_SKIP,
		VK_NEAR_SKIP,
		VK_EXTREMES,
		VK_ALL_ONES,
		VK_ALL_MIN,
		VK_ZERO
	} vertex_kind_t;

	localparam logic [DATA_W-1:0] INT_MIN_C = 32'h8000_0000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [DATA_W-1:0]        cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] sig_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [BUCKET_W-1:0]      bucket_index;
	logic [VERTEX_W-1:0]      vertex_index;
	logic [BAND_W-1:0]        band_index;

	lsh_band_bucket_hash_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sig_value    (sig_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.vertex_index (vertex_index),
		.band_index   (band_index)
	);

	logic [DATA_W-1:0] sig_stream [$];
	band_bucket_t      buckets_due [$];

	// banding hash state
	logic [DATA_W-1:0] base_reg = DEFAULT_BASE;
	logic [DATA_W-1:0] band_acc = '0;
	logic [DATA_W-1:0] power_acc = 32'd1;
	int                sig_pos = 0;
	logic              vertex_skipped = 1'b0;
	int                vertex_num = 0;

	int  in_gap = 0;
	int  out_stall = 0;
	bit  in_burst = 1'b0;
	bit  out_burst = 1'b0;
	int  mismatches = 0;
	int  values_taken = 0;
	int  buckets_checked = 0;
	int  vertices_skipped = 0;
	int  base_writes = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	function automatic logic [DATA_W-1:0] corner_value(input int k);
		case (k)
		0: return '0;
		1: return 32'd1;
		2: return '1;
		3: return INT_MIN_C;
		default: return SKIP_MARK;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] mixed_value();
		if ($urandom_range(0, 4) == 0)
			return corner_value($urandom_range(0, 4));
		return 32'($urandom);
	endfunction

	function automatic vertex_kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) return VK_RANDOM;
		if (roll < 77) return VK_SKIP;
		if (roll < 82) return VK_NEAR_SKIP;
		if (roll < 87) return VK_ALL_ONES;
		if (roll < 92) return VK_ALL_MIN;
		if (roll < 96) return VK_ZERO;
		return VK_EXTREMES;
	endfunction

	task automatic queue_vertex(input vertex_kind_t kind, input int len);
		logic [DATA_W-1:0] v;
		for (int p = 0; p < len; p++) begin
			case (kind)
			VK_SKIP:      v = (p == 0) ? SKIP_MARK : mixed_value();
			VK_NEAR_SKIP: v = (p == 0) ? SKIP_MARK - 32'd1 :
				(p % BAND_LEN == 0) ? SKIP_MARK : mixed_value();
			VK_EXTREMES:  v = (p == 0) ? INT_MIN_C : corner_value(p % 5);
			VK_ALL_ONES:  v = '1;
			VK_ALL_MIN:   v = INT_MIN_C;
			VK_ZERO:      v = '0;
			default:      v = mixed_value();
			endcase
			sig_stream.push_back(v);
		end
	endtask

	// one signature element through the band hash
	task automatic absorb_element(input logic [DATA_W-1:0] v);
		logic         last_elem;
		logic         band_end;
		int           band_no;
		longint       signed_sum;
		longint       rem;
		band_bucket_t rec;
		last_elem = (sig_pos + 1 >= SIG_LEN);
		band_end = ((sig_pos % BAND_LEN) == BAND_LEN - 1) || last_elem;
		band_no = sig_pos / BAND_LEN;
		if (sig_pos == 0) begin
			vertex_skipped = (v == SKIP_MARK);
			if (vertex_skipped)
				vertices_skipped++;
		end
		band_acc = band_acc + v * power_acc;
		power_acc = power_acc * base_reg;
		if (band_end) begin
			if (!vertex_skipped) begin
				signed_sum = $signed(band_acc);
				rem = signed_sum % BUCKET_COUNT;
				if (rem < 0)
					rem = rem + BUCKET_COUNT;
				rec.bucket = BUCKET_W'(rem);
				rec.vertex = VERTEX_W'(vertex_num);
				rec.band = BAND_W'(band_no);
				buckets_due.push_back(rec);
			end
			band_acc = '0;
			power_acc = 32'd1;
		end
		if (last_elem) begin
			sig_pos = 0;
			vertex_num = (vertex_num + 1 >= MAX_VERTICES) ? 0 : vertex_num + 1;
		end else begin
			sig_pos = sig_pos + 1;
		end
	endtask

	task automatic wait_drained();
		while (sig_stream.size() != 0 || in_valid || buckets_due.size() != 0)
			@(posedge clk);
		// skipped bands leave nothing to wait on, so cover the pipeline depth
		repeat (16) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (sig_stream.size() != 0) begin
				in_valid <= 1'b1;
				sig_value <= sig_stream.pop_front();
				in_gap <= in_burst ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			absorb_element(sig_value);
			values_taken++;
		end
	end

	// result monitor
	always @(posedge clk) begin : result_side
		int           nstall;
		band_bucket_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (buckets_due.size() == 0) begin
					$error("unexpected result bucket_index %0d vertex_index %0d band_index %0d",
						bucket_index, vertex_index, band_index);
					mismatches++;
				end else begin
					want = buckets_due.pop_front();
					buckets_checked++;
					if (bucket_index !== want.bucket) begin
						$error("bucket_index expected %0d actual %0d", want.bucket, bucket_index);
						mismatches++;
					end
					if (vertex_index !== want.vertex) begin
						$error("vertex_index expected %0d actual %0d", want.vertex, vertex_index);
						mismatches++;
					end
					if (band_index !== want.band) begin
						$error("band_index expected %0d actual %0d", want.band, band_index);
						mismatches++;
					end
				end
			end
			if (out_stall != 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				nstall = (out_burst || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
				out_ready <= (nstall == 0);
				out_stall <= (nstall == 0) ? 0 : nstall - 1;
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] phase_base;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				case (ph)
				1: phase_base = '0;
				2: phase_base = '1;
				3: phase_base = 32'd1;
				4: phase_base = INT_MIN_C;
				5: phase_base = 32'($urandom);
				default: phase_base = DEFAULT_BASE;
				endcase
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= phase_base;
				@(posedge clk);
				cfg_we <= 1'b0;
				base_reg = phase_base;
				base_writes++;
			end
			in_burst = (ph % 3 == 2);
			out_burst = (ph % 3 == 2);
			if (ph == 0) begin
				queue_vertex(VK_EXTREMES, SIG_LEN);
				queue_vertex(VK_SKIP, SIG_LEN);
				queue_vertex(VK_NEAR_SKIP, SIG_LEN);
			end else begin
				// realign after the base change that lands mid band
				if (ph == 4)
					queue_vertex(VK_RANDOM, SIG_LEN - 37);
				repeat (2) queue_vertex(pick_kind(), SIG_LEN);
				// stop inside a band so the next base takes effect mid band
				if (ph == 3)
					queue_vertex(VK_RANDOM, 37);
			end
			wait_drained();
		end
		$display("tb: %0d signature values taken, %0d vertices skipped, %0d band buckets checked",
			values_taken, vertices_skipped, buckets_checked);
		$display("tb: %0d hash base writes incl. 0, 1, all ones and the sign bit",
			base_writes);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
